@@ design/drkr_pkg.sv @@
// drkr_pkg: shared constants, types and register indices for the dual-role key resolver
// no dependencies
`timescale 1ns / 1ps
package drkr_pkg;
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_RESULTS = 8;
    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int NCW = $clog2(MAX_RESULTS + 1);
    localparam int PCT_FULL = 100;
    localparam int DLY_CAP = 255;
    localparam int DLY_NEG = 256;
    localparam int DVW = 23;
    localparam int DSW = 7;
    localparam int DCW = $clog2(DVW + 1);
    localparam int IN_TDATA_W = 80;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_TAP_HOLD = 2'd2;
    localparam logic [1:0] REG_OVERLAP  = 2'd3;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_SCAN, S_DSTART, S_DWAIT, S_DCHK, S_PUSH, S_NOFL, S_FIN
    } t_state;
endpackage

@@ design/drkr_div.sv @@
// drkr_div: restoring divider, one quotient bit per cycle
// depends on drkr_pkg
`timescale 1ns / 1ps
module drkr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [drkr_pkg::DVW-1:0]  i_dividend,
    input  logic [drkr_pkg::DSW-1:0]  i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [drkr_pkg::DVW-1:0]  o_quot
);
    import drkr_pkg::*;

    logic [DCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW-1:0] r_q;
    logic [DSW:0]   r_rem;
    logic [DSW-1:0] r_div;
    logic [DSW:0]   rem_sh;
    logic           ge;

    assign rem_sh = {r_rem[DSW-1:0], r_q[DVW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCW'(DVW);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_q   <= {r_q[DVW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ design/dual_role_key_resolver.sv @@
// dual_role_key_resolver: queue of key events with a sequencer that resolves dual-role keys
// one item runs up to 8 flushes, each a walk of the queue one slot a cycle that pauses
// for each overlap check (start, 23 divider steps, done and compare)
// not ready while an item is in work; one item at a time
// synchronous active-low reset clears the queue count, tap-hold flag and registers to defaults
// depends on drkr_pkg, drkr_div
`timescale 1ns / 1ps
module dual_role_key_resolver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // now[15:0] switch_addr[23:16] is_press[24] key_code[40:25] is_dual[41]
    // primary_code[57:42] alternate_code[73:58] space_cadet[74]
    input  logic [drkr_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // kind[0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_addr[7:0] out_press[8] out_key[24:9]
    output logic [drkr_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import drkr_pkg::*;

    logic [7:0]  r_addr [QUEUE_DEPTH];
    logic        r_press[QUEUE_DEPTH];
    logic [15:0] r_time [QUEUE_DEPTH];
    logic [15:0] r_key  [QUEUE_DEPTH];
    logic        r_dual [QUEUE_DEPTH];
    logic [15:0] r_prim [QUEUE_DEPTH];
    logic [15:0] r_alt  [QUEUE_DEPTH];
    logic        r_cadet[QUEUE_DEPTH];
    logic [QCW-1:0] r_count;
    logic           r_pend;

    logic        r_en;
    logic [15:0] r_hold_to;
    logic [15:0] r_tap_to;
    logic [6:0]  r_ovl;

    t_state r_state, n_state;
    logic           r_kind;
    logic [15:0]    r_now;
    logic [NCW-1:0] r_n;
    logic [QCW-1:0] r_i;
    logic           r_next_v;
    logic [15:0]    r_ntime;
    logic [15:0]    r_tend;
    logic [15:0]    r_d;
    logic           r_final;
    logic [7:0]     r_res_addr;
    logic           r_res_press;
    logic [15:0]    r_res_key;
    logic           r_held_v;
    logic [7:0]     r_held_addr;
    logic           r_held_press;
    logic [15:0]    r_held_key;
    logic           r_m_valid;
    logic           r_m_last;
    logic [24:0]    r_m_data;

    // decision outputs
    logic        fl_go;
    logic [15:0] fl_key;
    logic        clr_pend, set_pend, q_clear, next_set, inc_i, div_start, hold_go;

    logic [QIW-1:0] ii;
    logic           addr_mismatch;
    logic           other_released;
    logic           out_free;
    logic           m_load;
    logic [15:0]    el_head, el_one, el_end;
    logic           div_busy, div_done;
    logic [DVW-1:0] div_q;
    logic [DVW-1:0] dividend;
    logic [DVW-1:0] limit;
    logic [DVW-1:0] tmo;
    logic           delayed;

    assign ii       = r_i[QIW-1:0];
    assign out_free = !r_m_valid || i_m_tready;
    assign m_load   = r_held_v && out_free && (r_state == S_PUSH || r_state == S_FIN);
    assign el_head  = r_now - r_time[0];
    assign el_one   = r_now - r_time[1];
    assign el_end   = r_now - r_tend;

    always_comb begin
        addr_mismatch  = 1'b0;
        other_released = 1'b0;
        for (int j = 1; j < QUEUE_DEPTH; j++) begin
            if (QCW'(j) < r_count && r_addr[j] != r_addr[0])
                addr_mismatch = 1'b1;
            if (QCW'(j) < r_i && r_press[j] && r_addr[j] == r_addr[ii])
                other_released = 1'b1;
        end
    end

    // d*100 as shifts and adds
    assign dividend = (DVW'(r_d) << 6) + (DVW'(r_d) << 5) + (DVW'(r_d) << 2);

    drkr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_ovl),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign limit   = (div_q >= DVW'(r_d)) ? (div_q - DVW'(r_d)) : DVW'(DLY_NEG);
    assign tmo     = (limit < DVW'(DLY_NEG)) ? limit : DVW'(DLY_CAP);
    assign delayed = DVW'(el_end) < tmo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        fl_go     = 1'b0;
        fl_key    = r_key[0];
        clr_pend  = 1'b0;
        set_pend  = 1'b0;
        q_clear   = 1'b0;
        next_set  = 1'b0;
        inc_i     = 1'b0;
        div_start = 1'b0;
        hold_go   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_HEAD;
            end
            S_HEAD: begin
                priority if (r_n == NCW'(MAX_RESULTS)) begin
                    n_state = S_FIN;
                end else if (r_count == '0) begin
                    n_state = S_NOFL;
                end else if (!r_press[0]) begin
                    priority if (!r_pend) begin
                        fl_go = 1'b1; clr_pend = 1'b1;
                    end else if (r_count == QCW'(1)) begin
                        if (el_head <= r_tap_to) n_state = S_NOFL;
                        else begin fl_go = 1'b1; clr_pend = 1'b1; end
                    end else if (addr_mismatch) begin
                        fl_go = 1'b1; clr_pend = 1'b1;
                    end else if (r_count == QCW'(2)) begin
                        // tap then hold window over: both events vanish
                        if (el_one > r_tap_to) begin q_clear = 1'b1; clr_pend = 1'b1; end
                        n_state = S_NOFL;
                    end else begin
                        fl_go = 1'b1; clr_pend = 1'b1;
                    end
                end else if (!r_dual[0]) begin
                    fl_go = 1'b1;
                end else if (!r_en) begin
                    fl_go = 1'b1; fl_key = r_prim[0];
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (r_i >= r_count) begin
                    if (r_count >= QCW'(QUEUE_DEPTH)) begin
                        fl_go = 1'b1; fl_key = r_prim[0];
                    end else n_state = S_NOFL;
                end else if (r_press[ii]) begin
                    if (r_cadet[0]) begin
                        fl_go = 1'b1; fl_key = r_prim[0];
                    end else begin
                        next_set = !r_next_v; inc_i = 1'b1;
                    end
                end else if (r_addr[ii] == r_addr[0]) begin
                    if (!r_next_v || r_ovl == '0) begin
                        set_pend = (r_count == QCW'(2));
                        fl_go = 1'b1;
                        fl_key = r_cadet[0] ? r_alt[0] : r_prim[0];
                    end else n_state = S_DSTART;
                end else if (other_released) begin
                    fl_go = 1'b1; fl_key = r_alt[0];
                end else begin
                    inc_i = 1'b1;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) n_state = S_DCHK;
            end
            S_DCHK: begin
                if (delayed) begin
                    inc_i = 1'b1; n_state = S_SCAN;
                end else begin
                    fl_go = 1'b1; fl_key = r_prim[0];
                end
            end
            S_PUSH: begin
                if (!r_held_v || out_free) n_state = r_final ? S_FIN : S_HEAD;
            end
            S_NOFL: begin
                if (r_kind == KIND_TICK && r_count != '0 && !r_pend && r_press[0] &&
                    r_dual[0] && r_en && el_head >= r_hold_to) begin
                    hold_go = 1'b1;
                    fl_key  = r_cadet[0] ? r_prim[0] : r_alt[0];
                    n_state = S_PUSH;
                end else n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_held_v || out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (fl_go) n_state = S_PUSH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_en      <= 1'b1;
            r_hold_to <= 16'd250;
            r_tap_to  <= 16'd200;
            r_ovl     <= '0;
            r_held_v  <= 1'b0;
            r_m_valid <= 1'b0;
            r_final   <= 1'b0;
            r_n       <= '0;
            r_next_v  <= 1'b0;
            r_i       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ENABLE:   r_en      <= i_cfg_data[0];
                    REG_HOLD:     r_hold_to <= i_cfg_data;
                    REG_TAP_HOLD: r_tap_to  <= i_cfg_data;
                    REG_OVERLAP:  r_ovl     <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_m_valid && i_m_tready && !m_load) r_m_valid <= 1'b0;
            if (clr_pend) r_pend <= 1'b0;
            if (set_pend) r_pend <= 1'b1;
            if (q_clear)  r_count <= '0;
            if (next_set) begin
                r_next_v <= 1'b1;
                r_ntime  <= r_time[ii];
            end
            if (inc_i) r_i <= r_i + 1'b1;
            if (r_state == S_HEAD) begin
                r_i      <= QCW'(1);
                r_next_v <= 1'b0;
            end
            if (r_state == S_SCAN && n_state == S_DSTART) begin
                r_d    <= r_time[ii] - r_ntime;
                r_tend <= r_time[ii];
            end
            if (fl_go || hold_go) begin
                r_res_addr  <= r_addr[0];
                r_res_press <= hold_go ? 1'b1 : r_press[0];
                r_res_key   <= fl_key;
            end
            if (hold_go) r_final <= 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind  <= i_s_tuser;
                        r_now   <= i_s_tdata[15:0];
                        r_n     <= '0;
                        r_final <= 1'b0;
                        if (i_s_tuser == KIND_EVENT && r_count < QCW'(QUEUE_DEPTH)) begin
                            r_addr [r_count[QIW-1:0]] <= i_s_tdata[23:16];
                            r_press[r_count[QIW-1:0]] <= i_s_tdata[24];
                            r_time [r_count[QIW-1:0]] <= i_s_tdata[15:0];
                            r_key  [r_count[QIW-1:0]] <= i_s_tdata[40:25];
                            r_dual [r_count[QIW-1:0]] <= i_s_tdata[41];
                            r_prim [r_count[QIW-1:0]] <= i_s_tdata[57:42];
                            r_alt  [r_count[QIW-1:0]] <= i_s_tdata[73:58];
                            r_cadet[r_count[QIW-1:0]] <= i_s_tdata[74];
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_PUSH: begin
                    if (!r_held_v || out_free) begin
                        if (r_held_v) begin
                            r_m_valid <= 1'b1;
                            r_m_last  <= 1'b0;
                            r_m_data  <= {r_held_key, r_held_press, r_held_addr};
                        end
                        r_held_v     <= 1'b1;
                        r_held_addr  <= r_res_addr;
                        r_held_press <= r_res_press;
                        r_held_key   <= r_res_key;
                        r_n          <= r_n + 1'b1;
                        // drop the head slot
                        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                            r_addr[k]  <= r_addr[k+1];
                            r_press[k] <= r_press[k+1];
                            r_time[k]  <= r_time[k+1];
                            r_key[k]   <= r_key[k+1];
                            r_dual[k]  <= r_dual[k+1];
                            r_prim[k]  <= r_prim[k+1];
                            r_alt[k]   <= r_alt[k+1];
                            r_cadet[k] <= r_cadet[k+1];
                        end
                        r_count <= r_count - 1'b1;
                    end
                end
                S_FIN: begin
                    if (r_held_v && out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_last  <= 1'b1;
                        r_m_data  <= {r_held_key, r_held_press, r_held_addr};
                        r_held_v  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tlast   = r_m_last;
    assign o_m_tdata   = {7'd0, r_m_data};

`ifndef NO_ASSERTIONS
    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_held_v) else $error("result held while idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DWAIT)) else $error("divider busy outside wait");
    a_results_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NCW'(MAX_RESULTS + 1)) else $error("too many results");
`endif
endmodule
